/* design/rcnst_pkg.sv */
// Package for the role-counted note slot table.
// Holds command, event and role codes plus the item, result and slot entry types.
// No dependencies.
package rcnst_pkg;

    // Command codes
    localparam logic [1:0] CMD_START     = 2'd0;
    localparam logic [1:0] CMD_STOP      = 2'd1;
    localparam logic [1:0] CMD_STOP_ROLE = 2'd2;
    localparam logic [1:0] CMD_STOP_ALL  = 2'd3;

    // Event kinds
    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_ON   = 2'd1;
    localparam logic [1:0] EV_OFF  = 2'd2;

    // Holder roles; any other role code acts as playback
    localparam logic [1:0] ROLE_AUD  = 2'd0;
    localparam logic [1:0] ROLE_PRE  = 2'd1;
    localparam logic [1:0] ROLE_PLAY = 2'd2;

    localparam int         ROLE_NUM = 3;
    localparam logic [7:0] HOLD_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [15:0] pitch;
        logic [6:0]         velocity;
        logic [1:0]         role;
    } cmd_item_t;

    typedef struct packed {
        logic               accepted;
        logic [1:0]         event_kind;
        logic signed [15:0] event_pitch;
        logic [6:0]         event_velocity;
        logic [5:0]         event_slot;
        logic               last;
    } result_t;

    // One slot as stored in the slot RAM: pitch and one holder count per role
    typedef struct packed {
        logic signed [15:0]             pitch;
        logic [ROLE_NUM-1:0][7:0]       cnt;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

/* design/rcnst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the slot pitch and holder count store. No dependencies.
module rcnst_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 24
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, register one read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/role_counted_note_slot_table.sv */
// Role-counted note slot table: one command item in, one or more result items out.
// Start/stop scan the slots in order, skipping free slots and reading the slot RAM for
// active ones, and stop at the first pitch match or after the last slot.
// Stop-role and stop-all walk every slot the same way; each freed slot may also wait
// on the result register. One item is in work at a time. Reset clears all slots at once
// through the active bits; the slot RAM holds no reset and is read only for active slots.
module role_counted_note_slot_table #(
    parameter int SLOT_COUNT = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  rcnst_pkg::cmd_item_t cmd_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output rcnst_pkg::result_t   res_item
);

    import rcnst_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CHK = 3'd2;
    localparam logic [2:0] ST_SW_RD    = 3'd3;
    localparam logic [2:0] ST_SW_CHK   = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  found_reg, found_next;
    logic                  free_found_reg, free_found_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  res_valid_reg, res_valid_next;
    logic [SLOT_COUNT-1:0] active_reg, active_next;

    cmd_item_t             item_reg, item_next;
    logic [IW-1:0]         hit_idx_reg, hit_idx_next;
    logic [IW-1:0]         free_idx_reg, free_idx_next;
    slot_entry_t           hit_entry_reg, hit_entry_next;
    result_t               pend_reg, pend_next;
    result_t               res_reg, res_next;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    slot_entry_t           ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    slot_entry_t           rd_entry;

    logic                  out_free;
    logic                  last_idx;
    logic [1:0]            role_sel;
    slot_entry_t           sw_entry;
    logic                  sw_freed;
    logic                  sw_dirty;
    slot_entry_t           fin_entry;
    logic [IW-1:0]         fin_slot;

    rcnst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOT_COUNT)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign rd_entry  = slot_entry_t'(ram_rdata);
    assign out_free  = !res_valid_reg || !res_stall;
    assign last_idx  = (idx_reg == LAST_IDX);
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // Map role code to count lane; unknown code acts as playback
    always_comb
    begin
        case (item_reg.role)
            ROLE_AUD: role_sel = 2'd0;
            ROLE_PRE: role_sel = 2'd1;
            default:  role_sel = 2'd2;
        endcase
    end

    // Sequencer: scan or sweep the slots, then finish with the last result
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        free_found_next = free_found_reg;
        pend_valid_next = pend_valid_reg;
        res_valid_next  = res_valid_reg && res_stall;
        active_next     = active_reg;
        item_next       = item_reg;
        hit_idx_next    = hit_idx_reg;
        free_idx_next   = free_idx_reg;
        hit_entry_next  = hit_entry_reg;
        pend_next       = pend_reg;
        res_next        = res_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = rd_entry;
        sw_entry        = rd_entry;
        sw_freed        = 1'b0;
        sw_dirty        = 1'b0;
        fin_entry       = hit_entry_reg;
        fin_slot        = hit_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next       = cmd_item;
                    idx_next        = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    pend_valid_next = 1'b0;
                    if (cmd_item.cmd == CMD_START || cmd_item.cmd == CMD_STOP)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_SW_RD;
                    end
                end
            end

            ST_SCAN_RD:
            begin
                // Skip free slots without a read, note the lowest one
                if (!active_reg[idx_reg])
                begin
                    if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = idx_reg;
                    end
                    if (last_idx)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_SCAN_CHK;
                end
            end

            ST_SCAN_CHK:
            begin
                if (rd_entry.pitch == item_reg.pitch)
                begin
                    found_next     = 1'b1;
                    hit_idx_next   = idx_reg;
                    hit_entry_next = rd_entry;
                    state_next     = ST_FINISH;
                end
                else if (last_idx)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SW_RD:
            begin
                if (!active_reg[idx_reg])
                begin
                    if (last_idx)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next = ST_SW_CHK;
                end
            end

            ST_SW_CHK:
            begin
                // Drop the role's holders or free the slot outright
                if (item_reg.cmd == CMD_STOP_ALL)
                begin
                    sw_freed = 1'b1;
                end
                else if (rd_entry.cnt[role_sel] != 8'd0)
                begin
                    sw_entry.cnt[role_sel] = 8'd0;
                    sw_dirty = 1'b1;
                    sw_freed = (sw_entry.cnt == '0);
                end

                // Hold while the previous note-off cannot move out
                if (!(sw_freed && pend_valid_reg && !out_free))
                begin
                    if (sw_freed)
                    begin
                        active_next[idx_reg] = 1'b0;
                        if (pend_valid_reg)
                        begin
                            res_next       = pend_reg;
                            res_valid_next = 1'b1;
                        end
                        pend_next.accepted       = 1'b1;
                        pend_next.event_kind     = EV_OFF;
                        pend_next.event_pitch    = rd_entry.pitch;
                        pend_next.event_velocity = 7'd0;
                        pend_next.event_slot     = 6'(idx_reg);
                        pend_next.last           = 1'b0;
                        pend_valid_next          = 1'b1;
                    end
                    else if (sw_dirty)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_reg;
                        ram_wdata = sw_entry;
                    end
                    if (last_idx)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SW_RD;
                    end
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    res_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                    res_next.accepted       = 1'b1;
                    res_next.event_kind     = EV_NONE;
                    res_next.event_pitch    = '0;
                    res_next.event_velocity = 7'd0;
                    res_next.event_slot     = 6'd0;
                    res_next.last           = 1'b1;

                    case (item_reg.cmd)
                        CMD_START:
                        begin
                            if (!found_reg)
                            begin
                                fin_entry       = '0;
                                fin_entry.pitch = item_reg.pitch;
                                fin_slot        = free_idx_reg;
                            end
                            if (found_reg || free_found_reg)
                            begin
                                // Sound the note on its first holder
                                if (fin_entry.cnt == '0)
                                begin
                                    res_next.event_kind     = EV_ON;
                                    res_next.event_pitch    = item_reg.pitch;
                                    res_next.event_velocity = item_reg.velocity;
                                    res_next.event_slot     = 6'(fin_slot);
                                end
                                if (fin_entry.cnt[role_sel] != HOLD_MAX)
                                begin
                                    fin_entry.cnt[role_sel] = fin_entry.cnt[role_sel] + 8'd1;
                                end
                                ram_we                = 1'b1;
                                ram_waddr             = fin_slot;
                                ram_wdata             = fin_entry;
                                active_next[fin_slot] = 1'b1;
                            end
                            else
                            begin
                                res_next.accepted = 1'b0;
                            end
                        end

                        CMD_STOP:
                        begin
                            if (found_reg)
                            begin
                                if (fin_entry.cnt[role_sel] != 8'd0)
                                begin
                                    fin_entry.cnt[role_sel] = fin_entry.cnt[role_sel] - 8'd1;
                                end
                                // Free the slot once no role holds it
                                if (fin_entry.cnt == '0)
                                begin
                                    res_next.event_kind  = EV_OFF;
                                    res_next.event_pitch = hit_entry_reg.pitch;
                                    res_next.event_slot  = 6'(hit_idx_reg);
                                    active_next[hit_idx_reg] = 1'b0;
                                end
                                else
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = hit_idx_reg;
                                    ram_wdata = fin_entry;
                                end
                            end
                        end

                        default:
                        begin
                            // Flush the held note-off as the final result
                            if (pend_valid_reg)
                            begin
                                res_next      = pend_reg;
                                res_next.last = 1'b1;
                            end
                            pend_valid_next = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            active_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            found_reg      <= found_next;
            free_found_reg <= free_found_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            active_reg     <= active_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        hit_entry_reg <= hit_entry_next;
        pend_reg      <= pend_next;
        res_reg       <= res_next;
    end

    // Finishing always leaves a last result in the output register
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> (res_valid_reg && res_reg.last))
        else $error("finish did not produce a last result");

    // A held note-off exists only during a sweep command
    a_pend_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg != ST_IDLE &&
            (item_reg.cmd == CMD_STOP_ROLE || item_reg.cmd == CMD_STOP_ALL)))
        else $error("held note-off outside a sweep");

    // A refused start carries no event and ends the item
    a_refuse_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_reg.accepted) |->
            (res_reg.event_kind == EV_NONE && res_reg.last))
        else $error("refused start with an event or not last");

    // The slot pointer stays inside the table while busy
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg <= LAST_IDX))
        else $error("slot index out of range");

endmodule
